// ----- rtl/core/spi_nor_program_erase_sequencer_core_assert.svh -----
// Assertion macros shared by the checker of the flash sequencer.
// Each macro names its assertion with the given label and reports by $error.
`ifndef SPI_NOR_PROGRAM_ERASE_SEQUENCER_CORE_ASSERT_SVH
`define SPI_NOR_PROGRAM_ERASE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPNOR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPNOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");

`endif

// ----- rtl/core/spnor_pkg.sv -----
// ----------------------------------------------------------------------------
// spnor_pkg
// Types and constants shared by the serial NOR program/erase sequencer.
// ----------------------------------------------------------------------------
package spnor_pkg;

	// Flash geometry.
	localparam int unsigned PAGE_BYTES   = 256;
	localparam int unsigned SECTOR_BYTES = 4096;
	localparam int unsigned ADDR_BITS    = 24;
	localparam int unsigned ADDR_BYTES   = (ADDR_BITS + 7) / 8;
	localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

	// Room for the results caused by one request.
	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);
	localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

	// Flash opcodes.
	localparam logic [7:0] OP_WREN   = 8'h06;
	localparam logic [7:0] OP_PROG   = 8'h02;
	localparam logic [7:0] OP_SERASE = 8'h20;
	localparam logic [7:0] OP_RDSR   = 8'h05;

	localparam logic [24:0] USABLE_BYTES_RST = 25'd524288;
	localparam logic [23:0] POLL_LIMIT_RST   = 24'd10000000;

	typedef enum logic [1:0] {
		CMD_ERASE  = 2'd0,
		CMD_PROG   = 2'd1,
		CMD_DATA   = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_RANGE      = 3'd1,
		ST_ALIGN      = 3'd2,
		ST_TIMEOUT    = 3'd3,
		ST_UNEXPECTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DATA = 2'd1,
		PH_POLL = 2'd2
	} phase_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_USABLE_BYTES = 1'b0,
		REG_POLL_LIMIT   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		phase_t      phase;
		logic        op_is_erase;
		logic [23:0] current_address;
		logic [12:0] sectors_remaining;
		logic [8:0]  bytes_remaining;
		logic [23:0] poll_count;
	} state_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       byte_valid;
		logic       select_start;
		logic       select_end;
		logic       expect_reply;
		logic       op_done;
		logic [2:0] status_code;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] burst_t;

endpackage

// ----- rtl/core/spnor_req_if.sv -----
// ----------------------------------------------------------------------------
// spnor_req_if
// Request channel into the sequencer: valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface spnor_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [23:0] address;
	logic [24:0] length;
	logic [7:0]  data_byte;

	modport source (output valid, command, address, length, data_byte, input ready);
	modport sink   (input valid, command, address, length, data_byte, output ready);
	modport mon    (input valid, ready, command, address, length, data_byte);
endinterface

// ----- rtl/core/spnor_res_if.sv -----
// ----------------------------------------------------------------------------
// spnor_res_if
// Result channel out of the sequencer: valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface spnor_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] spi_byte;
	logic       byte_valid;
	logic       select_start;
	logic       select_end;
	logic       expect_reply;
	logic       op_done;
	logic [2:0] status_code;
	logic       last;

	modport source (output valid, spi_byte, byte_valid, select_start, select_end,
		expect_reply, op_done, status_code, last, input ready);
	modport sink   (input valid, spi_byte, byte_valid, select_start, select_end,
		expect_reply, op_done, status_code, last, output ready);
	modport mon    (input valid, ready, spi_byte, byte_valid, select_start, select_end,
		expect_reply, op_done, status_code, last);
endinterface

// ----- rtl/core/spnor_step.sv -----
// ----------------------------------------------------------------------------
// spnor_step
// Next-state and result-burst logic for one request of the sequencer.
// ----------------------------------------------------------------------------
module spnor_step (
	input  spnor_pkg::state_t  cur_state,
	input  logic [24:0]        usable_bytes,
	input  logic [23:0]        poll_limit,
	input  logic [1:0]         command,
	input  logic [23:0]        address,
	input  logic [24:0]        length,
	input  logic [7:0]         data_byte,
	output spnor_pkg::state_t  next_state,
	output spnor_pkg::burst_t  burst,
	output logic [spnor_pkg::CNT_W-1:0] count
);
	import spnor_pkg::*;

	function automatic result_t mk(input logic [7:0] b, input logic v, input logic ss,
		input logic se, input logic er, input logic done, input status_t st);
		result_t r;
		r.spi_byte     = b;
		r.byte_valid   = v;
		r.select_start = ss;
		r.select_end   = se;
		r.expect_reply = er;
		r.op_done      = done;
		r.status_code  = st;
		return r;
	endfunction

	// Header of a page program or sector erase: write enable, opcode, address.
	function automatic burst_t header(input logic [7:0] op, input logic [23:0] a,
		input logic end_frame);
		burst_t     bl;
		logic [31:0] aw;
		bl = '0;
		aw = {8'd0, a};
		bl[0] = mk(OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
		bl[1] = mk(op, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
		for (int i = 0; i < ADDR_BYTES; i++) begin
			bl[2+i] = mk(aw[8*(ADDR_BYTES-1-i) +: 8], 1'b1, 1'b0,
				end_frame && (i == ADDR_BYTES - 1), 1'b0, 1'b0, ST_OK);
		end
		return bl;
	endfunction

	// Sector erase followed by read-status and the first poll clock.
	function automatic burst_t erase_burst(input logic [23:0] a);
		burst_t bl;
		bl = header(OP_SERASE, a, 1'b1);
		bl[2+ADDR_BYTES] = mk(OP_RDSR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
		bl[3+ADDR_BYTES] = mk(8'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK);
		return bl;
	endfunction

	localparam logic [CNT_W-1:0] ERASE_CNT = CNT_W'(ADDR_BYTES + 4);
	localparam logic [CNT_W-1:0] PROG_CNT  = CNT_W'(ADDR_BYTES + 2);

	logic [24:0] addr_ext;
	logic        range_ok;
	logic        aligned;
	logic [8:0]  bytes_dec;
	logic [23:0] poll_inc;

	assign addr_ext = {1'b0, address};
	assign range_ok = (addr_ext <= usable_bytes) && (length <= usable_bytes - addr_ext);
	assign aligned  = (address[SECTOR_SHIFT-1:0] == '0) && (length[SECTOR_SHIFT-1:0] == '0);
	assign bytes_dec = (cur_state.bytes_remaining != '0) ?
		cur_state.bytes_remaining - 9'd1 : 9'd0;
	assign poll_inc = (cur_state.poll_count != 24'hFF_FFFF) ?
		cur_state.poll_count + 24'd1 : cur_state.poll_count;

	always_comb begin
		next_state = cur_state;
		burst      = '0;
		count      = CNT_W'(1);
		if (command == CMD_ERASE && cur_state.phase == PH_IDLE) begin
			if (!range_ok) begin
				burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_RANGE);
			end else if (!aligned) begin
				burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_ALIGN);
			end else if (length == '0) begin
				burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK);
			end else begin
				next_state.op_is_erase       = 1'b1;
				next_state.current_address   = address;
				next_state.sectors_remaining = 13'(length >> SECTOR_SHIFT);
				next_state.poll_count        = '0;
				next_state.phase             = PH_POLL;
				burst = erase_burst(address);
				count = ERASE_CNT;
			end
		end else if (command == CMD_PROG && cur_state.phase == PH_IDLE) begin
			if (!range_ok || length > 25'(PAGE_BYTES)) begin
				burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_RANGE);
			end else if (length == '0) begin
				burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK);
			end else begin
				next_state.op_is_erase     = 1'b0;
				next_state.current_address = address;
				next_state.bytes_remaining = length[8:0];
				next_state.phase           = PH_DATA;
				burst = header(OP_PROG, address, 1'b0);
				count = PROG_CNT;
			end
		end else if (command == CMD_DATA && cur_state.phase == PH_DATA) begin
			next_state.bytes_remaining = bytes_dec;
			burst[0] = mk(data_byte, 1'b1, 1'b0, bytes_dec == '0, 1'b0, 1'b0, ST_OK);
			if (bytes_dec == '0) begin
				burst[1] = mk(OP_RDSR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
				burst[2] = mk(8'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK);
				next_state.poll_count = '0;
				next_state.phase      = PH_POLL;
				count = CNT_W'(3);
			end
		end else if (command == CMD_STATUS && cur_state.phase == PH_POLL) begin
			next_state.poll_count = poll_inc;
			if (!data_byte[0]) begin
				if (cur_state.op_is_erase && cur_state.sectors_remaining > 13'd1) begin
					// Another sector follows; its write enable closes the poll frame.
					next_state.sectors_remaining = cur_state.sectors_remaining - 13'd1;
					next_state.current_address   =
						cur_state.current_address + 24'(SECTOR_BYTES);
					next_state.poll_count        = '0;
					burst = erase_burst(cur_state.current_address + 24'(SECTOR_BYTES));
					count = ERASE_CNT;
				end else begin
					next_state.sectors_remaining = '0;
					next_state.phase             = PH_IDLE;
					burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, ST_OK);
				end
			end else if (poll_inc >= poll_limit) begin
				next_state.phase = PH_IDLE;
				burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, ST_TIMEOUT);
			end else begin
				burst[0] = mk(8'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK);
			end
		end else begin
			burst[0] = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_UNEXPECTED);
		end
	end

endmodule

// ----- rtl/core/spi_nor_program_erase_sequencer_core.sv -----
// Serial NOR program/erase sequencer. Each accepted request (erase, program,
// program data byte or status reply byte) is decoded combinationally into a
// burst of one to seven wire-level results, which are then handed out one per
// cycle through an output register while the consumer is ready. A request
// holds the burst register until its last result has left it: a poll clock,
// a finish or a reject is one result, the final data byte of a program three,
// a program header five and a sector erase seven.
// The next request is taken in the same cycle in which the last result of the
// current burst moves to the output register, so a finished result waiting on
// a stalled consumer does not hold the request side back. Configuration
// registers (flash size and poll limit) must be written only while the block
// is idle.
// ----------------------------------------------------------------------------
// spi_nor_program_erase_sequencer_core
// Top level: configuration registers, sequencer state, burst register and
// result output register.
// ----------------------------------------------------------------------------
module spi_nor_program_erase_sequencer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [24:0]         cfg_data,
	spnor_req_if.sink           req,
	spnor_res_if.source         res
);
	import spnor_pkg::*;

	// Configuration registers.
	logic [24:0] usable_bytes_q;
	logic [23:0] poll_limit_q;

	// Sequencer state, updated once per accepted request.
	state_t state_q;
	state_t state_nxt;

	// Burst register: the results of the request being handed out.
	burst_t              burst_q;
	burst_t              burst_nxt;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_nxt;
	logic [IDX_W-1:0]    idx_q;

	// Output register.
	logic    out_valid_q;
	result_t out_item_q;
	logic    out_last_q;

	logic req_fire;
	logic move;
	logic move_last;

	spnor_step u_step (
		.cur_state    (state_q),
		.usable_bytes (usable_bytes_q),
		.poll_limit   (poll_limit_q),
		.command      (req.command),
		.address      (req.address),
		.length       (req.length),
		.data_byte    (req.data_byte),
		.next_state   (state_nxt),
		.burst        (burst_nxt),
		.count        (cnt_nxt)
	);

	// A result moves into the output register whenever the burst holds one and
	// the output register is empty or being emptied this cycle.
	assign move      = (cnt_q != '0) && (!out_valid_q || res.ready);
	assign move_last = move && ({1'b0, idx_q} == cnt_q - CNT_W'(1));

	// New requests are taken once the burst register is free, including the
	// cycle in which its last result leaves.
	assign req.ready = (cnt_q == '0) || move_last;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_bytes_q <= USABLE_BYTES_RST;
			poll_limit_q   <= POLL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USABLE_BYTES: usable_bytes_q <= cfg_data;
				REG_POLL_LIMIT:   poll_limit_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (req_fire) begin
				state_q <= state_nxt;
				cnt_q   <= cnt_nxt;
				idx_q   <= '0;
			end else if (move_last) begin
				cnt_q <= '0;
			end else if (move) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// The burst payload needs no reset; the count says what is live.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			burst_q <= burst_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_item_q <= burst_q[idx_q];
			out_last_q <= move_last;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.spi_byte     = out_item_q.spi_byte;
	assign res.byte_valid   = out_item_q.byte_valid;
	assign res.select_start = out_item_q.select_start;
	assign res.select_end   = out_item_q.select_end;
	assign res.expect_reply = out_item_q.expect_reply;
	assign res.op_done      = out_item_q.op_done;
	assign res.status_code  = out_item_q.status_code;
	assign res.last         = out_last_q;

endmodule

// ----- rtl/core/spnor_checker.sv -----
// ----------------------------------------------------------------------------
// spnor_checker
// Port-level checks of the sequencer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "spi_nor_program_erase_sequencer_core_assert.svh"

module spnor_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_spi_byte,
	input logic       res_byte_valid,
	input logic       res_select_start,
	input logic       res_expect_reply,
	input logic       res_op_done,
	input logic [2:0] res_status_code,
	input logic       res_last
);
	import spnor_pkg::*;

	logic        res_stall;
	logic [11:0] res_payload;
	logic        poll_shape;
	logic        done_shape;

	assign res_stall   = res_valid && !res_ready;
	assign res_payload = {res_spi_byte, res_status_code, res_last};
	assign poll_shape  = res_byte_valid && res_spi_byte == 8'd0 && res_last && !res_op_done;
	assign done_shape  = res_last && !res_byte_valid && !res_expect_reply;

	// A stalled result holds its payload.
	`SPNOR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, res_valid && $stable(res_payload))

	// A poll clock is always a driven zero byte and ends its burst.
	`SPNOR_ASSERT_IMPLY(a_poll_clock, clk, arst_n, res_valid && res_expect_reply, poll_shape)

	// A completion carries no byte and is the last result of its request.
	`SPNOR_ASSERT_IMPLY(a_done_last, clk, arst_n, res_valid && res_op_done, done_shape)

	// A status code appears only on a completion.
	`SPNOR_ASSERT_IMPLY(a_status_done, clk, arst_n, res_valid && !res_op_done, res_status_code == ST_OK)

	// A chip-select pulse always comes with an opcode on the bus.
	`SPNOR_ASSERT_IMPLY(a_select_byte, clk, arst_n, res_valid && res_select_start, res_byte_valid)

endmodule

bind spi_nor_program_erase_sequencer_core spnor_checker u_spnor_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_spi_byte     (res.spi_byte),
	.res_byte_valid   (res.byte_valid),
	.res_select_start (res.select_start),
	.res_expect_reply (res.expect_reply),
	.res_op_done      (res.op_done),
	.res_status_code  (res.status_code),
	.res_last         (res.last)
);

// ----- tb/tb_spi_nor_program_erase_sequencer_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_nor_program_erase_sequencer_core
// Self-checking bench for the serial NOR program/erase sequencer. A shadow
// copy of the sequencer state predicts the wire bytes of every accepted
// request, and every result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_spi_nor_program_erase_sequencer_core;
	import spnor_pkg::*;

	// Shadow of the sequencer. It tracks the configuration, the request phase and
	// the counters, and it queues the wire beats that each request must produce.
	class flash_seq_scoreboard;
		typedef struct packed {
			result_t fields;
			logic    last;
		} beat_t;

		beat_t       wire_beats[$];
		beat_t       burst[$];
		int unsigned errors;

		logic [24:0] usable_bytes;
		logic [23:0] poll_limit;
		phase_t      phase;
		logic        op_is_erase;
		logic [23:0] cur_addr;
		logic [12:0] sectors_left;
		logic [8:0]  bytes_left;
		logic [23:0] poll_count;

		function new();
			errors       = 0;
			usable_bytes = USABLE_BYTES_RST;
			poll_limit   = POLL_LIMIT_RST;
			phase        = PH_IDLE;
			op_is_erase  = 1'b0;
			cur_addr     = '0;
			sectors_left = '0;
			bytes_left   = '0;
			poll_count   = '0;
		endfunction

		function void write_register(reg_idx_t idx, logic [24:0] value);
			if (idx == REG_USABLE_BYTES)
				usable_bytes = value;
			else
				poll_limit = value[23:0];
		endfunction

		function int unsigned pending();
			return wire_beats.size();
		endfunction

		function void emit(logic [7:0] b, logic drive, logic cs_pulse, logic cs_raise,
			logic poll_clk, logic done, status_t code);
			beat_t x;
			x.fields.spi_byte     = b;
			x.fields.byte_valid   = drive;
			x.fields.select_start = cs_pulse;
			x.fields.select_end   = cs_raise;
			x.fields.expect_reply = poll_clk;
			x.fields.op_done      = done;
			x.fields.status_code  = code;
			x.last                = 1'b0;
			burst.push_back(x);
		endfunction

		// Address bytes go out most significant first; only an erase closes
		// the frame on the final one.
		function void emit_address(logic [23:0] a, logic close_frame);
			for (int i = ADDR_BYTES; i > 0; i--)
				emit(a[8*(i-1) +: 8], 1'b1, 1'b0, close_frame && (i == 1), 1'b0, 1'b0,
					ST_OK);
		endfunction

		function void start_status_poll();
			emit(OP_RDSR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
			emit(8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK);
			poll_count = '0;
			phase      = PH_POLL;
		endfunction

		function void erase_current_sector();
			emit(OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
			emit(OP_SERASE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
			emit_address(cur_addr, 1'b1);
			start_status_poll();
		endfunction

		function void close_request(logic cs_raise, status_t code);
			emit(8'h00, 1'b0, 1'b0, cs_raise, 1'b0, 1'b1, code);
			phase = PH_IDLE;
		endfunction

		function bit in_range(logic [23:0] addr, logic [24:0] len);
			int unsigned a, l, f;
			a = addr;
			l = len;
			f = usable_bytes;
			return (a <= f) && (l <= f - a);
		endfunction

		function void note_request(cmd_t cmd, logic [23:0] addr, logic [24:0] len,
			logic [7:0] data);
			if (cmd == CMD_ERASE && phase == PH_IDLE) begin
				if (!in_range(addr, len))
					close_request(1'b0, ST_RANGE);
				else if ((addr % SECTOR_BYTES) != 0 || (len % SECTOR_BYTES) != 0)
					close_request(1'b0, ST_ALIGN);
				else if (len == 0)
					close_request(1'b0, ST_OK);
				else begin
					op_is_erase  = 1'b1;
					cur_addr     = addr;
					sectors_left = 13'(len / SECTOR_BYTES);
					erase_current_sector();
				end
			end else if (cmd == CMD_PROG && phase == PH_IDLE) begin
				if (!in_range(addr, len) || len > PAGE_BYTES)
					close_request(1'b0, ST_RANGE);
				else if (len == 0)
					close_request(1'b0, ST_OK);
				else begin
					op_is_erase = 1'b0;
					cur_addr    = addr;
					bytes_left  = 9'(len);
					emit(OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
					emit(OP_PROG, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
					emit_address(addr, 1'b0);
					phase = PH_DATA;
				end
			end else if (cmd == CMD_DATA && phase == PH_DATA) begin
				if (bytes_left != 0)
					bytes_left--;
				emit(data, 1'b1, 1'b0, bytes_left == 0, 1'b0, 1'b0, ST_OK);
				if (bytes_left == 0)
					start_status_poll();
			end else if (cmd == CMD_STATUS && phase == PH_POLL) begin
				if (poll_count != 24'hFFFFFF)
					poll_count++;
				if (!data[0]) begin
					if (op_is_erase && sectors_left > 1) begin
						sectors_left--;
						cur_addr = cur_addr + 24'(SECTOR_BYTES);
						erase_current_sector();
					end else begin
						sectors_left = '0;
						close_request(1'b1, ST_OK);
					end
				end else if (poll_count >= poll_limit)
					close_request(1'b1, ST_TIMEOUT);
				else
					emit(8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK);
			end else begin
				// Ignored input: the state is kept, only the error beat comes out.
				emit(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_UNEXPECTED);
			end

			burst[burst.size()-1].last = 1'b1;
			foreach (burst[i])
				wire_beats.push_back(burst[i]);
			burst.delete();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got, logic got_last);
			beat_t want;
			if (wire_beats.size() == 0) begin
				$error("result beat arrived with no request outstanding");
				errors++;
				return;
			end
			want = wire_beats.pop_front();
			compare_field("spi_byte", want.fields.spi_byte, got.spi_byte);
			compare_field("byte_valid", want.fields.byte_valid, got.byte_valid);
			compare_field("select_start", want.fields.select_start, got.select_start);
			compare_field("select_end", want.fields.select_end, got.select_end);
			compare_field("expect_reply", want.fields.expect_reply, got.expect_reply);
			compare_field("op_done", want.fields.op_done, got.op_done);
			compare_field("status_code", want.fields.status_code, got.status_code);
			compare_field("last", want.last, got_last);
		endfunction
	endclass

	typedef enum {
		SINK_OPEN,
		SINK_JITTER,
		SINK_CHOKE
	} sink_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [24:0] cfg_data;

	spnor_req_if req_ch();
	spnor_res_if res_ch();

	flash_seq_scoreboard sb;
	int                  send_left;

	spi_nor_program_erase_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	always #5 clk = ~clk;

	// Hands one request to the sequencer and waits for the handshake. Requests
	// go out in bursts of random length; between bursts valid drops for a random
	// number of cycles, and some bursts follow each other without any gap.
	task automatic push_request(cmd_t cmd, logic [23:0] addr, logic [24:0] len,
		logic [7:0] data);
		int gap;
		if (send_left == 0) begin
			send_left = $urandom_range(1, 16);
			gap       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		send_left--;
		req_ch.valid     <= 1'b1;
		req_ch.command   <= cmd;
		req_ch.address   <= addr;
		req_ch.length    <= len;
		req_ch.data_byte <= data;
		do
			@(posedge clk);
		while (!req_ch.ready);
		// The request was taken at this edge, so the shadow state moves now.
		sb.note_request(cmd, addr, len, data);
	endtask

	// Holds the request side quiet until every predicted beat has come out.
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Configuration writes are only issued while the sequencer is idle. The
	// write enable drops again after each write so that writes never share a time step.
	task automatic write_register(reg_idx_t idx, logic [24:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.write_register(idx, value);
		@(posedge clk);
	endtask

	// Feeds data bytes or ready replies until the open request has finished.
	task automatic finish_operation();
		while (sb.phase != PH_IDLE) begin
			if (sb.phase == PH_DATA)
				push_request(CMD_DATA, 24'($urandom), 25'($urandom), 8'($urandom));
			else
				push_request(CMD_STATUS, 24'($urandom), 25'($urandom),
					{7'($urandom), 1'b0});
		end
	endtask

	// One random request, shaped by the shadow phase. Most traffic follows the
	// protocol (requests in idle, data bytes during a program, replies while
	// polling) so that multi-sector erases and timeouts are reached; the rest is
	// rejected requests and inputs that arrive in the wrong phase.
	task automatic random_item();
		int unsigned pick, sectors, max_sect, len;
		logic [7:0]  data;
		pick = $urandom_range(0, 99);
		data = 8'($urandom);
		case (sb.phase)
			PH_DATA: begin
				if (pick < 92)
					push_request(CMD_DATA, 24'($urandom), 25'($urandom), data);
				else
					push_request(cmd_t'($urandom_range(0, 3)), 24'($urandom),
						25'($urandom), data);
			end
			PH_POLL: begin
				// A busy reply asks for another poll clock or hits the poll limit.
				data[0] = ($urandom_range(0, 99) < 40);
				if (pick < 92)
					push_request(CMD_STATUS, 24'($urandom), 25'($urandom), data);
				else
					push_request(cmd_t'($urandom_range(0, 3)), 24'($urandom),
						25'($urandom), data);
			end
			default: begin
				if (pick < 40) begin
					max_sect = sb.usable_bytes / SECTOR_BYTES;
					sectors  = $urandom_range(1, 3);
					if (max_sect < sectors)
						push_request(CMD_ERASE, 24'd0, 25'(sectors * SECTOR_BYTES), data);
					else
						push_request(CMD_ERASE,
							24'($urandom_range(0, max_sect - sectors) * SECTOR_BYTES),
							25'(sectors * SECTOR_BYTES), data);
				end else if (pick < 75) begin
					len = ($urandom_range(0, 19) == 0) ? PAGE_BYTES : $urandom_range(1, 8);
					if (sb.usable_bytes >= len)
						push_request(CMD_PROG,
							24'($urandom_range(0, sb.usable_bytes - len)), 25'(len), data);
					else
						push_request(CMD_PROG, 24'($urandom), 25'(len), data);
				end else if (pick < 80) begin
					// Mostly out of range, with both commands.
					push_request(cmd_t'($urandom_range(0, 1)), 24'($urandom),
						25'($urandom), data);
				end else if (pick < 85) begin
					// Erase near the bottom of the flash, in most cases off a sector boundary.
					push_request(CMD_ERASE,
						24'($urandom_range(0, 15) * SECTOR_BYTES + $urandom_range(0, 1) * 512),
						25'(SECTOR_BYTES + $urandom_range(0, 1) * 100), data);
				end else if (pick < 92) begin
					push_request(cmd_t'($urandom_range(0, 1)),
						24'($urandom_range(0, sb.usable_bytes)), 25'd0, data);
				end else begin
					push_request(cmd_t'($urandom_range(2, 3)), 24'($urandom),
						25'($urandom), data);
				end
			end
		endcase
	endtask

	task automatic run_random(int count);
		repeat (count) begin
			random_item();
			// Now and then the sender holds off until the sequencer is empty.
			if ($urandom_range(0, 24) == 0)
				wait_all_results();
		end
		finish_operation();
		wait_all_results();
	endtask

	// Result side: every beat taken at a rising edge is checked against the
	// oldest prediction. Ready follows a mode that is drawn anew from time to
	// time: always open, lightly jittered, or mostly stalled.
	initial begin
		sink_mode_t  mode;
		int unsigned mode_cycles;
		result_t     got;
		res_ch.ready = 1'b0;
		mode         = SINK_OPEN;
		mode_cycles  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got.spi_byte     = res_ch.spi_byte;
				got.byte_valid   = res_ch.byte_valid;
				got.select_start = res_ch.select_start;
				got.select_end   = res_ch.select_end;
				got.expect_reply = res_ch.expect_reply;
				got.op_done      = res_ch.op_done;
				got.status_code  = res_ch.status_code;
				sb.check_result(got, res_ch.last);
			end
			if (mode_cycles == 0) begin
				mode        = sink_mode_t'($urandom_range(0, 2));
				mode_cycles = $urandom_range(20, 80);
			end
			mode_cycles--;
			case (mode)
				SINK_OPEN:   res_ch.ready <= arst_n;
				SINK_JITTER: res_ch.ready <= arst_n && ($urandom_range(0, 3) != 0);
				default:     res_ch.ready <= arst_n && ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Stimulus. Directed checks run first on the reset configuration, then the
	// random traffic steps through several flash sizes and poll limits.
	initial begin
		sb               = new();
		send_left        = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_USABLE_BYTES;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.command   = CMD_ERASE;
		req_ch.address   = '0;
		req_ch.length    = '0;
		req_ch.data_byte = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejects: all-ones fields, a program longer than a page, and erases
		// off a sector boundary in length and in offset.
		push_request(CMD_ERASE, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
		push_request(CMD_PROG, 24'h000000, 25'(PAGE_BYTES + 1), 8'h00);
		push_request(CMD_ERASE, 24'h001000, 25'd100, 8'h00);
		push_request(CMD_ERASE, 24'h000001, 25'(SECTOR_BYTES), 8'h00);
		// Zero-length requests finish at once, even at the very end of the flash.
		push_request(CMD_ERASE, 24'h002000, 25'd0, 8'h00);
		push_request(CMD_PROG, 24'h080000, 25'd0, 8'h00);
		// Data and status bytes with nothing in progress are flagged.
		push_request(CMD_DATA, 24'h000000, 25'd0, 8'h5A);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h00);

		// Two-sector erase ending at the top of the flash. While polling, a new
		// request and a data byte are flagged; a ready reply moves straight on to
		// the second sector, and a reply with only the busy bit clear ends it.
		push_request(CMD_ERASE, 24'h07E000, 25'(2 * SECTOR_BYTES), 8'h00);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'hFF);
		push_request(CMD_ERASE, 24'h000000, 25'(SECTOR_BYTES), 8'h00);
		push_request(CMD_DATA, 24'h000000, 25'd0, 8'h11);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h00);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h01);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'hFE);

		// One-byte program at the last flash byte, with wrong-phase inputs during
		// the data phase.
		push_request(CMD_PROG, 24'h07FFFF, 25'd1, 8'h00);
		push_request(CMD_PROG, 24'h000000, 25'd1, 8'h00);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h00);
		push_request(CMD_DATA, 24'h000000, 25'd0, 8'hFF);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h01);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h00);
		wait_all_results();

		run_random(15);

		// Largest flash and a poll limit of one: a busy reply times out at once,
		// which also cuts short an erase of the whole device.
		write_register(REG_USABLE_BYTES, 25'd16777216);
		write_register(REG_POLL_LIMIT, 25'd1);
		push_request(CMD_ERASE, 24'h000000, 25'd16777216, 8'h00);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h01);
		push_request(CMD_PROG, 24'hFFFFFF, 25'd1, 8'h00);
		push_request(CMD_DATA, 24'h000000, 25'd0, 8'hA5);
		push_request(CMD_STATUS, 24'h000000, 25'd0, 8'h03);
		wait_all_results();
		run_random(15);

		// Empty flash with a zero poll limit, then a random flash size while the
		// zero limit is still in place, so it acts as a limit of one.
		write_register(REG_USABLE_BYTES, 25'd0);
		write_register(REG_POLL_LIMIT, 25'd0);
		run_random(5);
		write_register(REG_USABLE_BYTES, 25'($urandom_range(32'h1000, 32'h100000)));
		run_random(10);

		// A short poll limit makes timeouts common in the middle of erases.
		write_register(REG_POLL_LIMIT, 25'($urandom_range(2, 4)));
		run_random(15);

		write_register(REG_USABLE_BYTES, USABLE_BYTES_RST);
		write_register(REG_POLL_LIMIT, 25'h0FFFFFF);
		run_random(15);

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog, several times the slowest expected run.
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
